// ===== src/tvp_pkg.sv =====
// ----------------------------------------------------------------------------
// tvp_pkg
// Shared types and codes for the trapezoid velocity profile generator.
// ----------------------------------------------------------------------------
package tvp_pkg;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_ACCEL = 2'd1;
    localparam logic [1:0] PH_BRAKE = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    localparam logic [1:0] REG_DISTANCE = 2'd0;
    localparam logic [1:0] REG_TOP      = 2'd1;
    localparam logic [1:0] REG_ACCEL    = 2'd2;
    localparam logic [1:0] REG_END      = 2'd3;

    // micro-operations issued by the controller to the datapath
    localparam logic [3:0] U_NONE  = 4'd0;
    localparam logic [3:0] U_START = 4'd1;
    localparam logic [3:0] U_ABORT = 4'd2;
    localparam logic [3:0] U_SQ_V  = 4'd3;
    localparam logic [3:0] U_SQ_F  = 4'd4;
    localparam logic [3:0] U_REM_A = 4'd5;
    localparam logic [3:0] U_BRAKE = 4'd6;
    localparam logic [3:0] U_SPEED = 4'd7;
    localparam logic [3:0] U_STEP  = 4'd8;
    localparam logic [3:0] U_POS   = 4'd9;
    localparam logic [3:0] U_DIV   = 4'd10;
    localparam logic [3:0] U_FIN   = 4'd11;

    localparam logic [31:0] BRAKE_FLOOR_SPEED = 32'h0005_0000;
    localparam logic [32:0] SNAP_MARGIN       = 33'd8192;
    localparam int          DIV_STEPS         = 31;

    typedef struct packed {
        logic       capture;
        logic [3:0] uop;
        logic       load_out;
    } tvp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       tick_live;
    } tvp_status_t;

endpackage

// ===== src/tvp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tvp_ctrl
// Sequencer: accepts one beat, walks the datapath through a tick, emits result.
// ----------------------------------------------------------------------------
module tvp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tvp_pkg::tvp_status_t status,
    output tvp_pkg::tvp_cmd_t    cmd
);
    import tvp_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_SQ_V     = 4'd2;
    localparam logic [3:0] S_SQ_F     = 4'd3;
    localparam logic [3:0] S_REM_A    = 4'd4;
    localparam logic [3:0] S_BRAKE    = 4'd5;
    localparam logic [3:0] S_SPEED    = 4'd6;
    localparam logic [3:0] S_STEP     = 4'd7;
    localparam logic [3:0] S_POS      = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    localparam logic [4:0] DIV_LAST = 5'(DIV_STEPS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.uop        = U_NONE;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.op == OP_START)
                begin
                    cmd.uop    = U_START;
                    state_next = S_OUT;
                end
                else if (status.op == OP_ABORT)
                begin
                    cmd.uop    = U_ABORT;
                    state_next = S_OUT;
                end
                else if (status.tick_live)
                begin
                    state_next = S_SQ_V;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SQ_V:
            begin
                cmd.uop    = U_SQ_V;
                state_next = S_SQ_F;
            end
            S_SQ_F:
            begin
                cmd.uop    = U_SQ_F;
                state_next = S_REM_A;
            end
            S_REM_A:
            begin
                cmd.uop    = U_REM_A;
                state_next = S_BRAKE;
            end
            S_BRAKE:
            begin
                cmd.uop    = U_BRAKE;
                state_next = S_SPEED;
            end
            S_SPEED:
            begin
                cmd.uop    = U_SPEED;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.uop    = U_STEP;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.uop    = U_POS;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.uop  = U_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.uop    = U_FIN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/tvp_dp.sv =====
// ----------------------------------------------------------------------------
// tvp_dp
// Datapath: config registers, motion state, shared multiplier, serial divider.
// ----------------------------------------------------------------------------
module tvp_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [1:0]           operation,
    input  logic [23:0]          tick_dt,
    input  tvp_pkg::tvp_cmd_t    cmd,
    output tvp_pkg::tvp_status_t status,
    output logic [1:0]           phase,
    output logic [31:0]          travelled,
    output logic [31:0]          velocity,
    output logic [31:0]          accel_now
);
    import tvp_pkg::*;

    logic [31:0] dist_cfg_reg, top_cfg_reg, acc_cfg_reg, end_cfg_reg;
    logic [1:0]  op_reg;
    logic [23:0] dt_reg;

    logic [1:0]  phase_reg;
    logic [31:0] goal_reg, pos_reg, speed_reg, old_speed_reg, accel_reg;
    logic        heading_reg;

    logic [63:0] prod_reg, v2_reg, f2_reg;
    logic [31:0] mul_a, mul_b;

    logic [24:0] drem_reg;
    logic [30:0] dshift_reg, quot_reg;
    logic        sat_reg, neg_reg;

    logic [1:0]  phase_out_reg;
    logic [31:0] trav_out_reg, vel_out_reg, acc_out_reg;

    // combinational helpers
    logic [32:0] remaining, snap_diff;
    logic [63:0] sq_diff;
    logic        brake_now;
    logic [31:0] target, dv, step;
    logic [32:0] sp_sum, pos_sum;
    logic [31:0] sp_new;
    logic [31:0] mag;
    logic [25:0] dtrial;
    logic [31:0] acc_val;
    logic [31:0] goal_start;

    assign status.op        = op_reg;
    assign status.tick_live = (op_reg == OP_TICK) && (dt_reg != '0) &&
                              ((phase_reg == PH_ACCEL) || (phase_reg == PH_BRAKE));

    assign phase     = phase_out_reg;
    assign travelled = trav_out_reg;
    assign velocity  = vel_out_reg;
    assign accel_now = acc_out_reg;

    always_comb
    begin
        case (cmd.uop)
            U_SQ_V:
            begin
                mul_a = speed_reg;
                mul_b = speed_reg;
            end
            U_SQ_F:
            begin
                mul_a = end_cfg_reg;
                mul_b = end_cfg_reg;
            end
            U_REM_A:
            begin
                mul_a = remaining[31:0];
                mul_b = acc_cfg_reg;
            end
            U_BRAKE:
            begin
                mul_a = acc_cfg_reg;
                mul_b = {8'd0, dt_reg};
            end
            default:
            begin
                mul_a = speed_reg;
                mul_b = {8'd0, dt_reg};
            end
        endcase
    end

    always_comb
    begin
        remaining = {1'b0, goal_reg} - {1'b0, pos_reg};
        sq_diff   = v2_reg - f2_reg;
        // remaining <= floor(diff / 2a) is the same as remaining * 2a <= diff
        brake_now = remaining[32] || (remaining == '0) ||
                    ((acc_cfg_reg != '0) && (v2_reg > f2_reg) &&
                     ({prod_reg, 1'b0} <= {1'b0, sq_diff}));

        if (phase_reg == PH_BRAKE)
        begin
            target = (end_cfg_reg == '0) ? BRAKE_FLOOR_SPEED : end_cfg_reg;
        end
        else
        begin
            target = top_cfg_reg;
        end
        dv     = prod_reg[55:24];
        sp_sum = {1'b0, speed_reg} + {1'b0, dv};
        if (speed_reg < target)
        begin
            sp_new = (sp_sum > {1'b0, target}) ? target : sp_sum[31:0];
        end
        else if (speed_reg > target)
        begin
            sp_new = (dv >= speed_reg - target) ? target : speed_reg - dv;
        end
        else
        begin
            sp_new = speed_reg;
        end

        step    = prod_reg[55:24];
        pos_sum = {1'b0, pos_reg} + {1'b0, step};

        mag = (speed_reg < old_speed_reg) ? old_speed_reg - speed_reg
                                          : speed_reg - old_speed_reg;

        dtrial = {drem_reg, dshift_reg[30]};

        if (sat_reg)
        begin
            acc_val = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            acc_val = neg_reg ? 32'd0 - {1'b0, quot_reg} : {1'b0, quot_reg};
        end

        snap_diff  = {1'b0, goal_reg} - {1'b0, pos_reg};
        goal_start = dist_cfg_reg[31] ? 32'd0 - dist_cfg_reg : dist_cfg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_cfg_reg <= '0;
            top_cfg_reg  <= '0;
            acc_cfg_reg  <= '0;
            end_cfg_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISTANCE: dist_cfg_reg <= cfg_data;
                REG_TOP:      top_cfg_reg  <= cfg_data;
                REG_ACCEL:    acc_cfg_reg  <= cfg_data;
                REG_END:      end_cfg_reg  <= cfg_data;
                default:      dist_cfg_reg <= dist_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= OP_TICK;
            dt_reg      <= '0;
            phase_reg   <= PH_IDLE;
            goal_reg    <= '0;
            heading_reg <= 1'b0;
            pos_reg     <= '0;
            speed_reg   <= '0;
            accel_reg   <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                op_reg <= operation;
                dt_reg <= tick_dt;
            end
            case (cmd.uop)
                U_START:
                begin
                    heading_reg <= dist_cfg_reg[31];
                    goal_reg    <= goal_start;
                    pos_reg     <= '0;
                    speed_reg   <= '0;
                    accel_reg   <= '0;
                    phase_reg   <= ((goal_start == '0) || (acc_cfg_reg == '0)) ?
                                   PH_DONE : PH_ACCEL;
                end
                U_ABORT:
                begin
                    heading_reg <= 1'b0;
                    goal_reg    <= '0;
                    pos_reg     <= '0;
                    speed_reg   <= '0;
                    accel_reg   <= '0;
                    phase_reg   <= PH_IDLE;
                end
                U_BRAKE:
                begin
                    if ((phase_reg == PH_ACCEL) && brake_now)
                    begin
                        phase_reg <= PH_BRAKE;
                    end
                end
                U_SPEED:
                begin
                    speed_reg <= sp_new;
                end
                U_POS:
                begin
                    pos_reg <= pos_sum[32] ? 32'hFFFF_FFFF : pos_sum[31:0];
                end
                U_FIN:
                begin
                    // snap to the goal once less than an eighth remains
                    if (snap_diff[32] || (snap_diff < SNAP_MARGIN))
                    begin
                        pos_reg   <= goal_reg;
                        speed_reg <= end_cfg_reg;
                        accel_reg <= '0;
                        phase_reg <= PH_DONE;
                    end
                    else
                    begin
                        accel_reg <= acc_val;
                    end
                end
                default:
                begin
                    phase_reg <= phase_reg;
                end
            endcase
        end
    end

    // arithmetic scratch and output data registers, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        case (cmd.uop)
            U_SQ_F:
            begin
                v2_reg <= prod_reg;
            end
            U_REM_A:
            begin
                f2_reg <= prod_reg;
            end
            U_SPEED:
            begin
                old_speed_reg <= speed_reg;
            end
            U_STEP:
            begin
                // quotient of (mag << 24) / dt saturates once mag >= dt << 7
                sat_reg    <= (mag >= {1'b0, dt_reg, 7'd0});
                neg_reg    <= (speed_reg < old_speed_reg) ^ heading_reg;
                drem_reg   <= mag[31:7];
                dshift_reg <= {mag[6:0], 24'd0};
                quot_reg   <= '0;
            end
            U_DIV:
            begin
                if (dtrial >= {2'b00, dt_reg})
                begin
                    drem_reg <= 25'(dtrial - {2'b00, dt_reg});
                    quot_reg <= {quot_reg[29:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dtrial[24:0];
                    quot_reg <= {quot_reg[29:0], 1'b0};
                end
                dshift_reg <= {dshift_reg[29:0], 1'b0};
            end
            default:
            begin
                v2_reg <= v2_reg;
            end
        endcase
        if (cmd.load_out)
        begin
            phase_out_reg <= phase_reg;
            trav_out_reg  <= pos_reg;
            vel_out_reg   <= speed_reg;
            acc_out_reg   <= accel_reg;
        end
    end

endmodule

// ===== src/trapezoid_velocity_profile.sv =====
// ----------------------------------------------------------------------------
// trapezoid_velocity_profile
// Trapezoidal motion profile generator with start, tick and abort commands.
// ----------------------------------------------------------------------------
// Usage:
//   Write the distance, cruise speed, acceleration and end speed registers
//   over the cfg channel (index 0..3) while the block is idle; cfg_ready is
//   always high. Each input beat carries an operation (tick, start, abort)
//   and tick_dt. Every input beat yields exactly one output beat with phase,
//   travelled, velocity and accel_now as they stand after the command.
// Timing:
//   Start, abort and ignored ticks go from dispatch straight to the output
//   state. A live tick runs seven sequencing steps around one shared
//   32x32 multiplier, a 31-step restoring divider for the acceleration
//   report and a finish step. One item is in flight at a time; in_ready
//   returns the cycle after the result is loaded into the output register.
// Reset and stall:
//   Reset clears control, config and motion registers to zero and idle;
//   while out_ready stays low the output beat holds, a new item may still
//   be accepted and worked on; its result waits until the output is free.
// ----------------------------------------------------------------------------
module trapezoid_velocity_profile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [23:0] tick_dt,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  phase,
    output logic [31:0] travelled,
    output logic [31:0] velocity,
    output logic [31:0] accel_now
);
    import tvp_pkg::*;

    tvp_cmd_t    cmd;
    tvp_status_t status;

    assign cfg_ready = 1'b1;

    tvp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tvp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .tick_dt   (tick_dt),
        .cmd       (cmd),
        .status    (status),
        .phase     (phase),
        .travelled (travelled),
        .velocity  (velocity),
        .accel_now (accel_now)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item accepted while busy");

    a_idle_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (phase == PH_IDLE)) |->
        ((travelled == '0) && (velocity == '0) && (accel_now == '0)))
        else $error("idle result with nonzero motion state");

    a_done_no_accel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (phase == PH_DONE)) |-> (accel_now == '0))
        else $error("finished move reports acceleration");

endmodule
